/* rtl/core/led_matrix_row_serializer_core_macros.svh */
// Assertion macros for the LED matrix row serialiser checker.
// Each macro expects signals named clk and rst in the enclosing scope.
`ifndef LED_MATRIX_ROW_SERIALIZER_CORE_MACROS_SVH
`define LED_MATRIX_ROW_SERIALIZER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LMRS_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lmrs assertion failed");

// Next-cycle implication, disabled during reset.
`define LMRS_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lmrs assertion failed");

`endif

/* rtl/core/lmrs_pkg.sv */
// Package for the LED matrix row serialiser: payload structs, codes and the
// control and status structs between controller and datapath. No dependencies.
package lmrs_pkg;

  localparam int MAX_PANELS_DEFAULT = 32;
  localparam int PIXELS_PER_PANEL   = 8;

  localparam logic [1:0] LAST_CHANNEL_PHASE = 2'd2;

  localparam logic OP_CHANNEL = 1'b0;
  localparam logic OP_COMMAND = 1'b1;

  localparam logic CFG_PANEL_COUNT = 1'b0;
  localparam logic CFG_THREE_MODE  = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] channel_value;
    logic [3:0] command_register;
    logic [7:0] command_value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] spi_byte;
    logic       end_of_transfer;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic emit_hdr;
    logic emit_dat;
  } ctrl_cmd_t;

  typedef struct packed {
    logic start_emit;
    logic last_panel;
    logic out_free;
  } dp_status_t;

endpackage

/* rtl/core/lmrs_ctrl.sv */
// Controller for the LED matrix row serialiser: sequences the header and data
// transfers of each panel. Depends on lmrs_pkg.
module lmrs_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  lmrs_pkg::dp_status_t sts,
  output lmrs_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HDR,
    ST_DAT
  } state_t;

  state_t state;

  assign in_stall     = (state != ST_IDLE);
  assign cmd.accept   = in_valid && (state == ST_IDLE);
  assign cmd.emit_hdr = (state == ST_HDR) && sts.out_free;
  assign cmd.emit_dat = (state == ST_DAT) && sts.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cmd.accept && sts.start_emit) begin
            state <= ST_HDR;
          end
        end
        ST_HDR: begin
          if (sts.out_free) begin
            state <= ST_DAT;
          end
        end
        ST_DAT: begin
          if (sts.out_free) begin
            state <= sts.last_panel ? ST_IDLE : ST_HDR;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/core/lmrs_dp.sv */
// Datapath for the LED matrix row serialiser: configuration registers, pixel
// packing, the row store and the output register. Depends on lmrs_pkg.
module lmrs_dp #(
  parameter int MAX_PANELS = lmrs_pkg::MAX_PANELS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic                 cfg_index,
  input  logic [5:0]           cfg_value,
  input  lmrs_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output lmrs_pkg::out_item_t  out_data,
  input  lmrs_pkg::ctrl_cmd_t  cmd,
  output lmrs_pkg::dp_status_t sts
);

  localparam int AW = (MAX_PANELS > 1) ? $clog2(MAX_PANELS) : 1;
  localparam logic [5:0] MaxN = 6'(MAX_PANELS);

  logic [5:0] panel_count;
  logic       three_channel_mode;

  logic [7:0] row_store [MAX_PANELS];
  logic [7:0] rd_data;
  logic [7:0] panel_byte;
  logic       pixel_lit;
  logic [1:0] channel_phase;
  logic [7:0] pixel_column;
  logic [2:0] row_number;

  logic [5:0] emit_idx;
  logic       emit_is_cmd;
  logic [7:0] hdr_byte;
  logic [7:0] cmd_byte;

  logic [5:0]    n_used;
  logic [8:0]    row_len;
  logic [8:0]    col_inc;
  logic          lit_next;
  logic          pixel_done;
  logic          row_end;
  logic [7:0]    panel_byte_next;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          pixel_step;

  always_comb begin
    if (panel_count == 6'd0) begin
      n_used = 6'd1;
    end else if (panel_count > MaxN) begin
      n_used = MaxN;
    end else begin
      n_used = panel_count;
    end
  end

  assign row_len         = {n_used, 3'b000};
  assign col_inc         = {1'b0, pixel_column} + 9'd1;
  assign lit_next        = pixel_lit || (in_data.channel_value != 8'd0);
  assign pixel_done      = !(three_channel_mode &&
                             (channel_phase < lmrs_pkg::LAST_CHANNEL_PHASE));
  assign row_end         = pixel_done && (col_inc >= row_len);
  assign panel_byte_next = {panel_byte[6:0], lit_next};
  assign pixel_step      = cmd.accept && (in_data.op == lmrs_pkg::OP_CHANNEL);
  assign wr_addr         = pixel_column[AW+2:3];
  assign rd_addr         = AW'(n_used - 6'd1 - emit_idx);

  assign sts.start_emit = (in_data.op == lmrs_pkg::OP_COMMAND) || row_end;
  assign sts.last_panel = ((emit_idx + 6'd1) == n_used);
  assign sts.out_free   = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      panel_count        <= 6'd1;
      three_channel_mode <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        lmrs_pkg::CFG_PANEL_COUNT: panel_count        <= cfg_value;
        lmrs_pkg::CFG_THREE_MODE:  three_channel_mode <= cfg_value[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      panel_byte    <= 8'd0;
      pixel_lit     <= 1'b0;
      channel_phase <= 2'd0;
      pixel_column  <= 8'd0;
      row_number    <= 3'd0;
    end else if (pixel_step) begin
      if (!pixel_done) begin
        pixel_lit     <= lit_next;
        channel_phase <= channel_phase + 2'd1;
      end else begin
        pixel_lit     <= 1'b0;
        channel_phase <= 2'd0;
        if (row_end) begin
          pixel_column <= 8'd0;
          panel_byte   <= 8'd0;
          row_number   <= row_number + 3'd1;
        end else begin
          pixel_column <= col_inc[7:0];
          panel_byte   <= panel_byte_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pixel_step && pixel_done && (pixel_column[2:0] == 3'd7)) begin
      row_store[wr_addr] <= panel_byte_next;
    end
    rd_data <= row_store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      emit_idx <= 6'd0;
    end else if (cmd.accept && sts.start_emit) begin
      emit_idx <= 6'd0;
    end else if (cmd.emit_dat) begin
      emit_idx <= emit_idx + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && sts.start_emit) begin
      emit_is_cmd <= (in_data.op == lmrs_pkg::OP_COMMAND);
      cmd_byte    <= in_data.command_value;
      if (in_data.op == lmrs_pkg::OP_COMMAND) begin
        hdr_byte <= {4'd0, in_data.command_register};
      end else begin
        hdr_byte <= {5'd0, row_number} + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_hdr || cmd.emit_dat) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_hdr) begin
      out_data.spi_byte        <= hdr_byte;
      out_data.end_of_transfer <= 1'b0;
    end else if (cmd.emit_dat) begin
      out_data.spi_byte        <= emit_is_cmd ? cmd_byte : rd_data;
      out_data.end_of_transfer <= sts.last_panel;
    end
  end

endmodule

/* rtl/core/led_matrix_row_serializer_core.sv */
// LED matrix row serialiser top level. Depends on lmrs_pkg, lmrs_ctrl, lmrs_dp.
// A channel byte is taken every cycle while the controller is idle; an item that ends
// a row, or a command, then holds the input while each panel in use gets one header
// and one data transfer through the single output register, longer under output stall.
// Output starts from the header state after acceptance. Reset is synchronous and
// clears control state, the pixel state and the configuration; no clearing pass.
module led_matrix_row_serializer_core #(
  parameter int MAX_PANELS = lmrs_pkg::MAX_PANELS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [5:0]          cfg_value,
  input  logic                in_valid,
  output logic                in_stall,
  input  lmrs_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output lmrs_pkg::out_item_t out_data
);

  lmrs_pkg::ctrl_cmd_t  cmd;
  lmrs_pkg::dp_status_t sts;

  assign cfg_ready = 1'b1;

  lmrs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  lmrs_dp #(
    .MAX_PANELS (MAX_PANELS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_value (cfg_value),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

/* rtl/core/lmrs_chk.sv */
// Port-level checker for the LED matrix row serialiser, bound to the top level.
// Depends on lmrs_pkg and led_matrix_row_serializer_core_macros.svh.
`include "led_matrix_row_serializer_core_macros.svh"

module lmrs_chk (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input lmrs_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input lmrs_pkg::out_item_t out_data
);

  // A command always produces output, so the input must close behind it.
  `LMRS_ASSERT_NEXT(a_cmd_stalls, in_valid && !in_stall && (in_data.op == lmrs_pkg::OP_COMMAND), in_stall)

  // Only the final byte of a run can be on show while the input is open.
  `LMRS_ASSERT_IMPL(a_mid_run_stalls, out_valid && !out_data.end_of_transfer, in_stall)

  // A stalled output transfer is held.
  `LMRS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

endmodule

bind led_matrix_row_serializer_core lmrs_chk u_lmrs_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

/* verif/lmrs_row_checker.sv */
// Checker for the LED matrix row serialiser: watches the register, input and output transfers,
// predicts the serial byte stream and compares it with what the block sends.
// Depends on lmrs_pkg for the payload structs and the register and operation codes.
module lmrs_row_checker #(
  parameter int MAX_PANELS = lmrs_pkg::MAX_PANELS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [5:0]          cfg_value,
  input  logic                in_valid,
  input  logic                in_stall,
  input  lmrs_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  lmrs_pkg::out_item_t out_data,
  output int unsigned         error_count,
  output int unsigned         pending_count,
  output int unsigned         result_count
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [7:0]  panel_row [MAX_PANELS];
  logic [7:0]  shift_byte;
  logic        pixel_on;
  logic [1:0]  channel_phase;
  int unsigned column;
  logic [2:0]  row_idx;
  logic [5:0]  panels_cfg;
  logic        three_mode;

  lmrs_pkg::out_item_t spi_bytes_due [$];
  lmrs_pkg::out_item_t due;
  int unsigned errors = 0;
  int unsigned results = 0;

  function automatic int unsigned panels_in_use();
    if (panels_cfg == 6'd0) return 1;
    if (panels_cfg > MAX_PANELS) return MAX_PANELS;
    return int'(panels_cfg);
  endfunction

  function automatic void queue_byte(input logic [7:0] value, input logic last);
    lmrs_pkg::out_item_t entry;
    entry.spi_byte        = value;
    entry.end_of_transfer = last;
    spi_bytes_due.push_back(entry);
  endfunction

  function automatic void predict_spi_bytes(input lmrs_pkg::in_item_t item);
    int unsigned n;
    int unsigned k;
    n = panels_in_use();
    if (item.op == lmrs_pkg::OP_COMMAND) begin
      for (k = 0; k < n; k++) begin
        queue_byte({4'd0, item.command_register}, 1'b0);
        queue_byte(item.command_value, k + 1 == n);
      end
      return;
    end
    if (item.channel_value != 8'd0) pixel_on = 1'b1;
    if (three_mode && channel_phase < lmrs_pkg::LAST_CHANNEL_PHASE) begin
      channel_phase = channel_phase + 2'd1;
      return;
    end
    channel_phase = 2'd0;
    shift_byte = {shift_byte[6:0], pixel_on};
    pixel_on = 1'b0;
    if (column % 8 == 7) panel_row[(column / 8) % MAX_PANELS] = shift_byte;
    column++;
    if (column < n * 8) return;
    column = 0;
    shift_byte = 8'd0;
    for (k = 0; k < n; k++) begin
      queue_byte(8'(row_idx) + 8'd1, 1'b0);
      queue_byte(panel_row[(n - 1 - k) % MAX_PANELS], k + 1 == n);
    end
    row_idx = row_idx + 3'd1;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_PANELS; i++) panel_row[i] = 8'd0;
      shift_byte    = 8'd0;
      pixel_on      = 1'b0;
      channel_phase = 2'd0;
      column        = 0;
      row_idx       = 3'd0;
      panels_cfg    = 6'd1;
      three_mode    = 1'b0;
      spi_bytes_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == lmrs_pkg::CFG_PANEL_COUNT) begin
          panels_cfg = cfg_value;
        end else begin
          three_mode = cfg_value[0];
        end
      end
      if (in_valid && !in_stall) predict_spi_bytes(in_data);
      if (out_valid && !out_stall) begin
        results++;
        if (spi_bytes_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected transfer, expected none, got byte %02h end %b",
                   $time, out_data.spi_byte, out_data.end_of_transfer);
        end else begin
          due = spi_bytes_due.pop_front();
          if (out_data.spi_byte !== due.spi_byte) begin
            errors++;
            $display("%0t: spi_byte mismatch, expected %02h, got %02h",
                     $time, due.spi_byte, out_data.spi_byte);
          end
          if (out_data.end_of_transfer !== due.end_of_transfer) begin
            errors++;
            $display("%0t: end_of_transfer mismatch, expected %b, got %b",
                     $time, due.end_of_transfer, out_data.end_of_transfer);
          end
        end
      end
    end
    error_count   <= errors;
    pending_count <= spi_bytes_due.size();
    result_count  <= results;
  end

endmodule

/* verif/led_matrix_row_serializer_core_test.sv */
// Top of the LED matrix row serialiser testbench: clock, reset, stimulus, output stalls
// and the verdict. Depends on lmrs_pkg, lmrs_row_checker and led_matrix_row_serializer_core.
module led_matrix_row_serializer_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ITEM_TARGET   = 480;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned DRAIN_CYCLES  = 10;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned IDLE_LIMIT    = 3000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_index = lmrs_pkg::CFG_PANEL_COUNT;
  logic [5:0] cfg_value = 6'd0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  lmrs_pkg::in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  lmrs_pkg::out_item_t out_data;

  int unsigned error_count;
  int unsigned pending_count;
  int unsigned result_count;

  int unsigned items_sent = 0;
  int unsigned commands_sent = 0;
  int unsigned rows_sent = 0;
  int unsigned settings_written = 0;
  int unsigned holds_requested = 0;
  int unsigned holds_done = 0;
  int unsigned idle_cycles = 0;
  bit          eager = 1'b0;

  led_matrix_row_serializer_core uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_value (cfg_value),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  lmrs_row_checker row_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_value     (cfg_value),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .error_count   (error_count),
    .pending_count (pending_count),
    .result_count  (result_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int unsigned sender_gap();
    int unsigned r;
    if (eager) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 82) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(10, 40);
  endfunction

  function automatic lmrs_pkg::in_item_t channel_item(input logic [7:0] value);
    lmrs_pkg::in_item_t item;
    item.op               = lmrs_pkg::OP_CHANNEL;
    item.channel_value    = value;
    item.command_register = 4'($urandom);
    item.command_value    = 8'($urandom);
    return item;
  endfunction

  function automatic lmrs_pkg::in_item_t command_item(input logic [3:0] addr,
                                                      input logic [7:0] value);
    lmrs_pkg::in_item_t item;
    item.op               = lmrs_pkg::OP_COMMAND;
    item.channel_value    = 8'($urandom);
    item.command_register = addr;
    item.command_value    = value;
    return item;
  endfunction

  function automatic logic [7:0] random_channel(input logic three);
    if ($urandom_range(0, 99) < (three ? 60 : 45)) return 8'd0;
    if ($urandom_range(0, 7) == 0) return 8'd1 << $urandom_range(0, 7);
    return 8'($urandom_range(1, 255));
  endfunction

  function automatic logic [5:0] mode_word(input logic three);
    return {5'($urandom_range(0, 31)), three};
  endfunction

  task automatic send_item(input lmrs_pkg::in_item_t item);
    int unsigned gap;
    gap = sender_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (item.op == lmrs_pkg::OP_COMMAND) commands_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(input logic reg_index, input logic [5:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= reg_index;
    cfg_value <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    settings_written++;
  endtask

  // Output side: alternating runs of stalls and free cycles, with the occasional long hold.
  initial begin
    int unsigned run_left;
    logic        stalling;
    run_left = 0;
    stalling = 1'b0;
    forever begin
      @(posedge clk);
      if (holds_done < holds_requested) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
        stalling = 1'b0;
        run_left = 2;
        holds_done++;
      end else if (run_left > 0) begin
        run_left--;
      end else begin
        stalling = !stalling;
        if (stalling) begin
          run_left = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40);
        end else begin
          run_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 4);
        end
        out_stall <= stalling;
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Timed out after %0d cycles without a transfer.", idle_cycles);
        $display("led_matrix_row_serializer_core_test: errors");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0]  row_tail [7];
    int unsigned phase_no;
    int unsigned big_left;
    int unsigned r;
    int unsigned panels;
    int unsigned used;
    int unsigned rows;
    int unsigned row_bytes;
    logic        three;

    row_tail = '{8'h01, 8'h00, 8'h80, 8'h00, 8'h00, 8'h10, 8'h00};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // A mode change part way through a pixel: the byte seen in three-channel mode still lights it.
    set_reg(lmrs_pkg::CFG_PANEL_COUNT, 6'd1);
    set_reg(lmrs_pkg::CFG_THREE_MODE, mode_word(1'b1));
    send_item(channel_item(8'hFF));
    settle();
    set_reg(lmrs_pkg::CFG_THREE_MODE, mode_word(1'b0));
    send_item(channel_item(8'h00));
    foreach (row_tail[i]) send_item(channel_item(row_tail[i]));
    rows_sent++;

    // Shrinking the panel count part way through a row ends the row at the next pixel.
    settle();
    set_reg(lmrs_pkg::CFG_PANEL_COUNT, 6'd2);
    repeat (9) send_item(channel_item(random_channel(1'b0)));
    settle();
    set_reg(lmrs_pkg::CFG_PANEL_COUNT, 6'd1);
    send_item(channel_item(8'hFF));
    rows_sent++;

    // Out-of-range panel counts are clamped to one and to the maximum.
    settle();
    set_reg(lmrs_pkg::CFG_PANEL_COUNT, 6'd0);
    send_item(command_item(4'h0, 8'h00));
    settle();
    set_reg(lmrs_pkg::CFG_PANEL_COUNT, 6'd63);
    send_item(command_item(4'hF, 8'hFF));

    phase_no = 0;
    big_left = 2;
    while (items_sent < ITEM_TARGET || phase_no <= 3) begin
      settle();
      r = $urandom_range(0, 99);
      three = 1'($urandom_range(0, 1));
      if ((phase_no == 1 || r >= 95) && big_left > 0) begin
        panels = $urandom_range(32, 63);
        three = 1'b0;
        big_left--;
      end else if (r < 70) begin
        panels = $urandom_range(1, 4);
      end else if (r < 84) begin
        panels = $urandom_range(5, 8);
      end else if (r < 90) begin
        panels = 0;
      end else begin
        panels = $urandom_range(9, 16);
        three = 1'b0;
      end
      eager = ($urandom_range(0, 3) == 0);
      rows = $urandom_range(1, 3);
      if (phase_no == 3) begin
        panels = $urandom_range(2, 4);
        three = 1'b0;
        rows = 3;
        eager = 1'b1;
      end
      if ($urandom_range(0, 1) == 0) begin
        set_reg(lmrs_pkg::CFG_PANEL_COUNT, 6'(panels));
        set_reg(lmrs_pkg::CFG_THREE_MODE, mode_word(three));
      end else begin
        set_reg(lmrs_pkg::CFG_THREE_MODE, mode_word(three));
        set_reg(lmrs_pkg::CFG_PANEL_COUNT, 6'(panels));
      end
      used = (panels == 0) ? 1 : (panels > 32) ? 32 : panels;
      row_bytes = used * 8 * (three ? 3 : 1);
      if (row_bytes > 64) rows = 1;
      if (phase_no == 3) holds_requested++;
      repeat (rows) begin
        for (int b = 0; b < row_bytes; b++) begin
          if ($urandom_range(0, 11) == 0) begin
            send_item(command_item(4'($urandom), 8'($urandom)));
          end
          send_item(channel_item(random_channel(three)));
        end
        rows_sent++;
      end
      phase_no++;
    end
    eager = 1'b0;

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d items (%0d commands, %0d complete rows) with %0d register writes.",
             items_sent, commands_sent, rows_sent, settings_written);
    $display("Checked %0d serial bytes, including %0d long output hold(s).",
             result_count, holds_done);
    if (error_count == 0 && pending_count == 0) begin
      $display("led_matrix_row_serializer_core_test: clean");
    end else begin
      $display("led_matrix_row_serializer_core_test: errors");
    end
    $finish;
  end

endmodule
